// File: rtl/core/cpsd_pkg.sv
package cpsd_pkg;

    localparam int ACC_WIDTH_DEFAULT   = 32;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int SYMBOL_WIDTH    = 8;
    localparam int REG_WIDTH       = 16;
    localparam int INDEX_WIDTH     = 16;
    localparam int KIND_WIDTH      = 3;
    localparam int CODE_WIDTH      = 3;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef logic [SYMBOL_WIDTH-1:0]    t_symbol;
    typedef logic [KIND_WIDTH-1:0]      t_kind;
    typedef logic [CODE_WIDTH-1:0]      t_code;
    typedef logic [CFG_INDEX_WIDTH-1:0] t_cfg_index;

    localparam t_kind KIND_HYP  = 3'd0;
    localparam t_kind KIND_REF  = 3'd1;
    localparam t_kind KIND_BACK = 3'd2;
    localparam t_kind KIND_ADD  = 3'd3;
    localparam t_kind KIND_ERR  = 3'd4;

    localparam t_code ERR_NONE  = 3'd0;
    localparam t_code ERR_CHAR  = 3'd1;
    localparam t_code ERR_Z     = 3'd2;
    localparam t_code ERR_RANGE = 3'd3;
    localparam t_code ERR_MID   = 3'd4;
    localparam t_code ERR_COUNT = 3'd5;

    localparam t_cfg_index CFG_MANDATORY_HYP_COUNT = 2'd0;
    localparam t_cfg_index CFG_REFERRED_STMT_COUNT = 2'd1;

    localparam t_symbol CH_A = 8'h41;
    localparam t_symbol CH_T = 8'h54;
    localparam t_symbol CH_U = 8'h55;
    localparam t_symbol CH_Y = 8'h59;
    localparam t_symbol CH_Z = 8'h5A;

endpackage

// File: rtl/core/compressed_proof_step_decoder_unit.sv
// Channel   | Direction | Handshake                 | Payload
// input     | in        | i_in_valid / o_in_ready   | i_symbol, i_last_symbol
// result    | out       | o_out_valid / i_out_ready | o_step_kind, o_step_index,
//           |           |                           | o_error_code, o_end_of_proof
// config    | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One symbol is taken per cycle while input ready is high; its result, if any, appears in the result
// register on the cycle after the transfer.
// The rate is set by the single result register, which can be refilled in the
// cycle in which it is emptied.
// Reset is synchronous and clears the decoder state and both count registers.
// Input ready is low only while a held result is not being taken.
module compressed_proof_step_decoder_unit
    import cpsd_pkg::*;
#(
    parameter int ACC_WIDTH   = ACC_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [REG_WIDTH-1:0]   i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SYMBOL_WIDTH-1:0] i_symbol,
    input  logic                   i_last_symbol,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [KIND_WIDTH-1:0]  o_step_kind,
    output logic [INDEX_WIDTH-1:0] o_step_index,
    output logic [CODE_WIDTH-1:0]  o_error_code,
    output logic                   o_end_of_proof
);

    localparam int PW = ACC_WIDTH + 3;
    localparam int FW = ACC_WIDTH + 5;
    localparam int CW = (ACC_WIDTH > COUNT_WIDTH) ? ACC_WIDTH : COUNT_WIDTH;
    localparam int TW = CW + 2;

    logic [REG_WIDTH-1:0]   r_mhc;
    logic [REG_WIDTH-1:0]   r_rsc;
    logic [ACC_WIDTH-1:0]   r_acc, n_acc;
    logic                   r_pending, n_pending;
    logic                   r_after, n_after;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_error_seen, n_error_seen;

    logic                   r_out_valid;
    t_kind                  r_kind;
    logic [INDEX_WIDTH-1:0] r_index;
    t_code                  r_code;
    logic                   r_end;

    logic                   w_fire;
    logic                   w_is_prefix, w_is_final;
    logic [2:0]             w_pd;
    logic [4:0]             w_fd;
    logic [PW-1:0]          w_prefix_sum;
    logic [FW-1:0]          w_final_sum;
    logic                   w_prefix_ovf, w_final_ovf;
    logic [ACC_WIDTH-1:0]   w_num;
    logic [TW-1:0]          w_t1, w_t2, w_t3;
    logic [TW-1:0]          w_num_x, w_rem1, w_rem2;
    logic                   w_lt_hyp, w_lt_ref, w_lt_back;
    logic                   w_emit;
    t_kind                  w_kind;
    logic [INDEX_WIDTH-1:0] w_index;
    t_code                  w_err;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;

    assign w_is_prefix = (i_symbol >= CH_U) && (i_symbol <= CH_Y);
    assign w_is_final  = (i_symbol >= CH_A) && (i_symbol <= CH_T);
    assign w_pd = 3'(i_symbol - CH_U + 8'd1);
    assign w_fd = 5'(i_symbol - CH_A + 8'd1);

    assign w_prefix_sum = ({3'b000, r_acc} << 2) + {3'b000, r_acc} + PW'(w_pd);
    assign w_final_sum  = ({5'b00000, r_acc} << 4) + ({5'b00000, r_acc} << 2)
                        + FW'(w_fd);
    assign w_prefix_ovf = |w_prefix_sum[PW-1:ACC_WIDTH];
    assign w_final_ovf  = |w_final_sum[FW-1:ACC_WIDTH];
    assign w_num        = w_final_sum[ACC_WIDTH-1:0] - ACC_WIDTH'(1);

    // The range boundaries come from registers only, so the three compares
    // run side by side after the multiply-add.
    assign w_t1 = TW'(r_mhc);
    assign w_t2 = TW'(r_mhc) + TW'(r_rsc);
    assign w_t3 = w_t2 + TW'(r_count);

    assign w_num_x   = TW'(w_num);
    assign w_lt_hyp  = w_num_x < w_t1;
    assign w_lt_ref  = w_num_x < w_t2;
    assign w_lt_back = w_num_x < w_t3;
    assign w_rem1    = w_num_x - w_t1;
    assign w_rem2    = w_num_x - w_t2;

    always_comb begin
        n_acc        = r_acc;
        n_pending    = r_pending;
        n_after      = r_after;
        n_count      = r_count;
        n_error_seen = r_error_seen;
        w_emit       = 1'b0;
        w_kind       = KIND_HYP;
        w_index      = '0;
        w_err        = ERR_NONE;
        if (!r_error_seen) begin
            if (w_is_prefix) begin
                if (w_prefix_ovf) begin
                    w_err = ERR_RANGE;
                end else begin
                    n_acc     = w_prefix_sum[ACC_WIDTH-1:0];
                    n_pending = 1'b1;
                    n_after   = 1'b0;
                end
            end else if (w_is_final) begin
                if (w_final_ovf) begin
                    w_err = ERR_RANGE;
                end else begin
                    n_acc     = '0;
                    n_pending = 1'b0;
                    n_after   = 1'b1;
                    if (w_lt_hyp) begin
                        w_kind  = KIND_HYP;
                        w_index = w_num_x[INDEX_WIDTH-1:0];
                        w_emit  = 1'b1;
                    end else if (w_lt_ref) begin
                        w_kind  = KIND_REF;
                        w_index = w_rem1[INDEX_WIDTH-1:0];
                        w_emit  = 1'b1;
                    end else if (w_lt_back) begin
                        w_kind  = KIND_BACK;
                        w_index = w_rem2[INDEX_WIDTH-1:0];
                        w_emit  = 1'b1;
                    end else begin
                        w_err = ERR_RANGE;
                    end
                end
            end else if (i_symbol == CH_Z) begin
                if (!r_after) begin
                    w_err = ERR_Z;
                end else if (&r_count) begin
                    w_err = ERR_COUNT;
                end else begin
                    n_count = r_count + COUNT_WIDTH'(1);
                    n_after = 1'b0;
                    w_kind  = KIND_ADD;
                    w_emit  = 1'b1;
                end
            end else begin
                w_err = ERR_CHAR;
            end

            if ((w_err == ERR_NONE) && i_last_symbol && n_pending) begin
                w_err = ERR_MID;
            end
            if (w_err != ERR_NONE) begin
                w_emit       = 1'b1;
                w_kind       = KIND_ERR;
                w_index      = '0;
                n_error_seen = 1'b1;
            end
        end
        if (i_last_symbol) begin
            n_acc        = '0;
            n_pending    = 1'b0;
            n_after      = 1'b0;
            n_count      = '0;
            n_error_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mhc <= '0;
            r_rsc <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MANDATORY_HYP_COUNT) begin
                r_mhc <= i_cfg_data;
            end else if (i_cfg_index == CFG_REFERRED_STMT_COUNT) begin
                r_rsc <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_pending    <= 1'b0;
            r_after      <= 1'b0;
            r_count      <= '0;
            r_error_seen <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_fire) begin
                r_acc        <= n_acc;
                r_pending    <= n_pending;
                r_after      <= n_after;
                r_count      <= n_count;
                r_error_seen <= n_error_seen;
                r_out_valid  <= w_emit;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_kind  <= w_kind;
            r_index <= w_index;
            r_code  <= w_err;
            r_end   <= i_last_symbol;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_step_kind    = r_kind;
    assign o_step_index   = r_index;
    assign o_error_code   = r_code;
    assign o_end_of_proof = r_end;

endmodule

// File: rtl/core/cpsd_checker.sv
module cpsd_checker
    import cpsd_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic [SYMBOL_WIDTH-1:0] i_symbol,
    input logic                    i_last_symbol,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [KIND_WIDTH-1:0]   o_step_kind,
    input logic [INDEX_WIDTH-1:0]  o_step_index,
    input logic [CODE_WIDTH-1:0]   o_error_code,
    input logic                    o_end_of_proof
);

    // A stalled result must hold until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_step_kind)
            && $stable(o_step_index) && $stable(o_error_code)
            && $stable(o_end_of_proof))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_symbol)
            && $stable(i_last_symbol))
        else $error("input symbol changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_code_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_step_kind == KIND_ERR) == (o_error_code != ERR_NONE)))
        else $error("error code does not match step kind");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_step_kind == KIND_ADD || o_step_kind == KIND_ERR)
            |-> o_step_index == '0)
        else $error("non-zero index on add-reference or error step");

endmodule

bind compressed_proof_step_decoder_unit cpsd_checker u_cpsd_checker (.*);
